// ----- hdl/mpfd_pkg.sv -----
// Shared constants and types for the monochrome page framebuffer drawer.
// No dependencies.
`default_nettype none
package mpfd_pkg;
  localparam int ScreenWidth  = 128;
  localparam int ScreenHeight = 64;
  localparam int PageCount    = (ScreenHeight + 7) / 8;
  localparam int StoreBytes   = PageCount * ScreenWidth;
  localparam int AddrW        = $clog2(StoreBytes);
  localparam int ColW         = $clog2(ScreenWidth);

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_POINT = 3'd1,
    MODE_LINE  = 3'd2,
    MODE_RING  = 3'd3,
    MODE_DISC  = 3'd4,
    MODE_READ  = 3'd5
  } mode_t;
endpackage
`default_nettype wire

// ----- hdl/mono_page_framebuffer_drawer_unit.sv -----
// Top level of the monochrome page framebuffer drawer.
// Depends on mpfd_pkg and mpfd_ram.
//
// One command beat enters on s_axis; one result beat leaves on m_axis.
// s_axis_tuser: mode[2:0].
// s_axis_tdata from bit 0: x_a[8:0], y_a[17:9], x_b[26:18], y_b[35:27],
// radius[41:36], ink[42], read_page[45:43], read_column[52:46], zero above.
// m_axis_tdata: read_data[7:0], zero for every command but a read.
// Pixels are written by a read-modify-write of one store byte through the
// single RAM port, in the states RD, WAIT, WR and NEXT per line pixel and
// CAND, RD, WAIT, WR and NEXT per circle candidate. The next command can
// be accepted in the cycle after the result beat. s_axis_tready is low
// from acceptance until the result beat has been taken.
// After reset the block sweeps the 1024-byte store to zero and accepts no
// command meanwhile. A stalled m_axis holds its beat and keeps
// s_axis_tready low.
`default_nettype none
module mono_page_framebuffer_drawer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [2:0]  s_axis_tuser,  // mode
  input  wire logic [55:0] s_axis_tdata,  // x_a, y_a, x_b, y_b, radius, ink, page, column
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // read_data
);
  import mpfd_pkg::*;

  typedef enum logic [3:0] {
    ST_WIPE, ST_IDLE, ST_CAND, ST_RD, ST_WAIT, ST_WR, ST_NEXT, ST_RDATA, ST_OUT
  } state_t;

  state_t            state;
  logic [2:0]        mode;
  logic signed [9:0] px, py, xb, yb, cx, cy, ox, oy, rr;
  logic signed [10:0] acc, dx, dy;
  logic              sx, sy, ink;
  logic [12:0]       d2;
  logic [11:0]       outer, inner;
  logic [AddrW:0]    wcnt;
  logic [AddrW-1:0]  addr;
  logic [7:0]        wdata, rdata, rbyte;
  logic              we;

  mpfd_ram #(.Width(8), .Depth(StoreBytes)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic onscreen;
  assign onscreen = (px >= 0) && (px < ScreenWidth) && (py >= 0) && (py < ScreenHeight);

  logic [AddrW-1:0] pix_addr;
  assign pix_addr = AddrW'((py[9:0] >> 3) * ScreenWidth) + AddrW'(px[9:0]);

  logic [7:0] bitm;
  assign bitm = 8'(1) << py[2:0];

  logic signed [19:0] sq;
  logic signed [9:0]  sq_in;
  assign sq_in = (state == ST_CAND) ? oy : ox;
  assign sq = sq_in * sq_in;

  // Write gating: the pixel write only happens for qualifying pixels.
  logic keep;
  assign keep = onscreen && ((mode != MODE_RING && mode != MODE_DISC) ||
                ((d2 <= 13'(outer)) && (mode == MODE_DISC || d2 >= 13'(inner))));

  always_comb begin
    we = 1'b0;
    wdata = ink ? (rdata | bitm) : (rdata & ~bitm);
    addr = pix_addr;
    if (state == ST_WIPE || (state == ST_WR && mode == MODE_CLEAR)) begin
      we = 1'b1;
      wdata = '0;
      addr = wcnt[AddrW-1:0];
    end else if (state == ST_WR) begin
      we = keep;
    end else if ((state == ST_RD || state == ST_WAIT) && mode == MODE_READ) begin
      addr = AddrW'(yb[2:0] * ScreenWidth) + AddrW'(xb[ColW-1:0]);
    end
  end

  logic lastpt;
  assign lastpt = (mode == MODE_LINE) ? (px == xb && py == yb)
                                      : (ox == rr && oy == rr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
      wcnt <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_WIPE: begin
          wcnt <= wcnt + 1'b1;
          if (wcnt == (AddrW+1)'(StoreBytes - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mode <= s_axis_tuser;
            px <= 10'(signed'(s_axis_tdata[8:0]));
            py <= 10'(signed'(s_axis_tdata[17:9]));
            cx <= 10'(signed'(s_axis_tdata[8:0]));
            cy <= 10'(signed'(s_axis_tdata[17:9]));
            xb <= (s_axis_tuser == MODE_READ) ? 10'(s_axis_tdata[52:46])
                                              : 10'(signed'(s_axis_tdata[26:18]));
            yb <= (s_axis_tuser == MODE_READ) ? 10'(s_axis_tdata[45:43])
                                              : 10'(signed'(s_axis_tdata[35:27]));
            rr <= 10'(s_axis_tdata[41:36]);
            ox <= -10'(s_axis_tdata[41:36]);
            oy <= -10'(s_axis_tdata[41:36]);
            outer <= 12'(s_axis_tdata[41:36]) * 12'(s_axis_tdata[41:36]);
            inner <= (s_axis_tdata[41:36] == 6'd0) ? 12'd4095 :
                     (12'(s_axis_tdata[41:36]) - 12'd1) * (12'(s_axis_tdata[41:36]) - 12'd1);
            ink <= s_axis_tdata[42];
            rbyte <= '0;
            wcnt <= '0;
            case (s_axis_tuser)
              MODE_CLEAR: state <= ST_WR;
              MODE_POINT: state <= ST_RD;
              MODE_LINE: state <= ST_RD;
              MODE_RING, MODE_DISC: state <= ST_CAND;
              MODE_READ: state <= ST_RD;
              default: state <= ST_OUT;
            endcase
          end
        end
        ST_CAND: begin
          d2 <= 13'(sq);
          px <= cx + ox;
          py <= cy + oy;
          state <= ST_RD;
        end
        ST_RD: begin
          if (mode == MODE_RING || mode == MODE_DISC) begin
            d2 <= d2 + 13'(sq);
            state <= ST_WAIT;
          end else if (mode == MODE_READ) begin
            state <= ST_WAIT;
          end else begin
            state <= ST_WAIT;
            if (mode == MODE_LINE && px == cx && py == cy) begin
              dx <= (xb > px) ? (11'(xb) - 11'(px)) : (11'(px) - 11'(xb));
              dy <= (yb > py) ? (11'(yb) - 11'(py)) : (11'(py) - 11'(yb));
              sx <= px < xb;
              sy <= py < yb;
            end
          end
        end
        ST_WAIT: begin
          if (mode == MODE_READ) begin
            state <= ST_RDATA;
          end else begin
            state <= ST_WR;
            if (mode == MODE_LINE && px == cx && py == cy)
              acc <= (dx > dy) ? (dx >>> 1) : -(dy >>> 1);
          end
        end
        ST_WR: begin
          if (mode == MODE_CLEAR) begin
            wcnt <= wcnt + 1'b1;
            if (wcnt == (AddrW+1)'(StoreBytes - 1)) state <= ST_OUT;
          end else begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (mode == MODE_POINT || lastpt) begin
            state <= ST_OUT;
          end else if (mode == MODE_LINE) begin
            if (acc > -dx) begin
              px <= sx ? px + 10'sd1 : px - 10'sd1;
            end
            if (acc < dy) begin
              py <= sy ? py + 10'sd1 : py - 10'sd1;
            end
            acc <= acc - ((acc > -dx) ? dy : 11'sd0) + ((acc < dy) ? dx : 11'sd0);
            state <= ST_RD;
          end else begin
            if (ox == rr) begin
              ox <= -rr;
              oy <= oy + 10'sd1;
            end else begin
              ox <= ox + 10'sd1;
            end
            state <= ST_CAND;
          end
        end
        ST_RDATA: begin
          rbyte <= (yb < PageCount) ? rdata : 8'd0;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= rbyte;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  logic unused;
  assign unused = ^s_axis_tdata[55:53];

  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  a_wipe_first: assert property (@(posedge clk)
    rst |=> !s_axis_tready) else $error("ready during wipe");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped");
endmodule
`default_nettype wire

// ----- hdl/mpfd_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module mpfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for mono_page_framebuffer_drawer_unit: drives drawing commands as
// stream beats and checks every result beat against a software frame store.
// Depends on mpfd_pkg and the RTL of the drawer.
`default_nettype none
module tb;
  import mpfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0] mode;
    logic signed [8:0] x_a, y_a, x_b, y_b;
    logic [5:0] radius;
    logic ink;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } draw_cmd_t;

  class frame_scoreboard;
    logic [7:0] pixels [StoreBytes];
    logic [7:0] expected_bytes [$];
    int errors;

    function void clear_store();
      foreach (pixels[i]) pixels[i] = 8'h00;
    endfunction

    function void plot(int x, int y, logic ink);
      int idx;
      if (x < 0 || x >= ScreenWidth || y < 0 || y >= ScreenHeight) return;
      idx = (y >> 3) * ScreenWidth + x;
      pixels[idx][y & 7] = ink;
    endfunction

    function void trace_line(int xa, int ya, int xb, int yb, logic ink);
      int dx, dy, sx, sy, acc, prev;
      dx = xb > xa ? xb - xa : xa - xb;
      dy = yb > ya ? yb - ya : ya - yb;
      sx = xa < xb ? 1 : -1;
      sy = ya < yb ? 1 : -1;
      acc = dx > dy ? dx / 2 : -(dy / 2);
      forever begin
        plot(xa, ya, ink);
        if (xa == xb && ya == yb) break;
        prev = acc;
        if (prev > -dx) begin
          acc -= dy;
          xa += sx;
        end
        if (prev < dy) begin
          acc += dx;
          ya += sy;
        end
      end
    endfunction

    function void fill_circle(int cx, int cy, int r, bit ring, logic ink);
      int d2;
      for (int oy = -r; oy <= r; oy++)
        for (int ox = -r; ox <= r; ox++) begin
          d2 = ox * ox + oy * oy;
          if (d2 > r * r) continue;
          if (ring && d2 < (r - 1) * (r - 1)) continue;
          plot(cx + ox, cy + oy, ink);
        end
    endfunction

    function void note_command(draw_cmd_t c);
      logic [7:0] rd;
      rd = 8'h00;
      case (c.mode)
        MODE_CLEAR: clear_store();
        MODE_POINT: plot(c.x_a, c.y_a, c.ink);
        MODE_LINE:  trace_line(c.x_a, c.y_a, c.x_b, c.y_b, c.ink);
        MODE_RING:  fill_circle(c.x_a, c.y_a, c.radius, 1'b1, c.ink);
        MODE_DISC:  fill_circle(c.x_a, c.y_a, c.radius, 1'b0, c.ink);
        MODE_READ:  rd = pixels[c.read_page * ScreenWidth + c.read_column];
        default:    rd = 8'h00;
      endcase
      expected_bytes.push_back(rd);
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        $error("read_data: unexpected beat, actual %0h", got);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        $error("read_data: expected %0h, actual %0h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [2:0] s_axis_tuser = '0;
  logic [55:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  frame_scoreboard frame_model;
  int burst_left = 0;

  always #4 clk = ~clk;

  mono_page_framebuffer_drawer_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  function automatic logic [55:0] pack_cmd(draw_cmd_t c);
    return {3'b000, c.read_column, c.read_page, c.ink, c.radius, c.y_b, c.x_b, c.y_a, c.x_a};
  endfunction

  task automatic send_cmd(draw_cmd_t c);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.mode;
    s_axis_tdata <= pack_cmd(c);
    do @(posedge clk); while (!s_axis_tready);
    frame_model.note_command(c);
    @(negedge clk);
  endtask

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int sel;
    c.mode = 3'($urandom_range(0, 7));
    sel = $urandom_range(0, 99);
    if (sel < 3) c.mode = MODE_CLEAR;
    else if (sel < 40) c.mode = MODE_READ;
    else if (sel < 55) c.mode = MODE_POINT;
    else if (sel < 75) c.mode = MODE_LINE;
    else if (sel < 86) c.mode = MODE_RING;
    else if (sel < 95) c.mode = MODE_DISC;
    c.x_a = $urandom_range(0, 9) == 0 ? 9'($urandom) : 9'($urandom_range(0, 140) - 6);
    c.y_a = $urandom_range(0, 9) == 0 ? 9'($urandom) : 9'($urandom_range(0, 76) - 6);
    c.x_b = $urandom_range(0, 9) == 0 ? 9'($urandom) : 9'($urandom_range(0, 140) - 6);
    c.y_b = $urandom_range(0, 9) == 0 ? 9'($urandom) : 9'($urandom_range(0, 76) - 6);
    c.radius = $urandom_range(0, 19) == 0 ? 6'($urandom) : 6'($urandom_range(0, 12));
    c.ink = $urandom_range(0, 3) != 0;
    c.read_page = 3'($urandom);
    c.read_column = 7'($urandom);
    return c;
  endfunction

  function automatic draw_cmd_t make_cmd(logic [2:0] m, int xa, int ya, int xb, int yb,
                                         int r, logic ink, int pg, int col);
    draw_cmd_t c;
    c.mode = m;
    c.x_a = 9'(xa);
    c.y_a = 9'(ya);
    c.x_b = 9'(xb);
    c.y_b = 9'(yb);
    c.radius = 6'(r);
    c.ink = ink;
    c.read_page = 3'(pg);
    c.read_column = 7'(col);
    return c;
  endfunction

  always begin
    @(negedge clk);
    if (rst) m_axis_tready <= 1'b0;
    else if (($time / 640) % 4 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= $urandom_range(0, 2) != 0;
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) frame_model.check_result(m_axis_tdata);

  initial begin
    #80ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    frame_model = new();
    frame_model.clear_store();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_POINT, 0, 0, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_POINT, 127, 63, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_POINT, -256, 255, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_POINT, 128, 64, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 7, 127));
    send_cmd(make_cmd(MODE_LINE, -10, -5, 140, 70, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_LINE, 100, 2, 3, 60, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_LINE, 20, 20, 20, 20, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 2, 20));
    send_cmd(make_cmd(MODE_RING, 64, 32, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_RING, 64, 32, 0, 0, 10, 1, 0, 0));
    send_cmd(make_cmd(MODE_DISC, 30, 30, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_DISC, 0, 0, 0, 0, 63, 0, 0, 0));
    send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 4, 64));
    send_cmd(make_cmd(3'd6, 255, -256, 255, -256, 63, 1, 7, 127));
    send_cmd(make_cmd(3'd7, 0, 0, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_POINT, 5, 9, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 1, 1, 5));
    send_cmd(make_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 1, 1, 5));
    repeat (1830) send_cmd(random_cmd());
    s_axis_tvalid <= 1'b0;
    fork
      begin
        while (frame_model.expected_bytes.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
      end
      begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
      end
    join_any
    if (frame_model.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
